>>> hdl/tmpl_pkg.sv
package tmpl_pkg;

	// operand, product and accumulator widths of the shared multiply unit
	localparam int OP_W   = 33;
	localparam int PROD_W = 66;
	localparam int ACC_W  = 68;
	localparam int FRAC_W = 16;
	localparam int VERT_W = 10;
	localparam int TRI_W  = 3 * VERT_W;
	localparam int CNT_W  = 12;

	typedef enum logic [1:0] {
		REQ_NODE   = 2'd0,
		REQ_TRI    = 2'd1,
		REQ_LOCATE = 2'd2,
		REQ_EDGE   = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRI_RD,
		ST_NODE_RD,
		ST_NODE_CAP,
		ST_CALC,
		ST_CHECK_S,
		ST_CHECK_T,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic acc_ld;
	} mac_ctl_t;

	// (i+1)%3
	function automatic logic [1:0] next3(input logic [1:0] i);
		logic [1:0] r;
		case (i)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// (i+2)%3
	function automatic logic [1:0] prev3(input logic [1:0] i);
		logic [1:0] r;
		case (i)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/tmpl_ram.sv
module tmpl_ram #(
	parameter int W = 32,
	parameter int D = 1024,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/tmpl_mac.sv
module tmpl_mac import tmpl_pkg::*; (
	input  logic                    clk,
	input  mac_ctl_t                ctl,
	input  logic signed [OP_W-1:0]  op_a,
	input  logic signed [OP_W-1:0]  op_b,
	output logic signed [ACC_W-1:0] diff
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= op_a * op_b;
		end
		if (ctl.acc_ld) begin
			acc_q <= prod_ext;
		end
	end

	assign prod_ext = {{(ACC_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	// first product minus second product
	assign diff = acc_q - prod_ext;

endmodule

>>> hdl/triangle_mesh_point_locator_core.sv
// Write items (node, triangle) are stored on transfer; the block stays idle and ready.
// Locate: for each triangle scanned, a triangle read, 3 node reads and a capture, then the
// edge tests on the shared multiplier, ending at the first hit or after the last triangle.
// Edge query: the same reads, multiplier terms per edge tried, and a 16-bit division on a hit.
// One item at a time; a result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous) clears control and count_q; the stores are not cleared.
module triangle_mesh_point_locator_core import tmpl_pkg::*; #(
	parameter int MAX_NODES     = 1024,
	parameter int MAX_TRIANGLES = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [10:0]        item_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [VERT_W-1:0]  vert_a,
	input  logic [VERT_W-1:0]  vert_b,
	input  logic [VERT_W-1:0]  vert_c,
	input  logic signed [31:0] disp_x,
	input  logic signed [31:0] disp_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [10:0]        found_triangle,
	output logic [1:0]         crossed_edge,
	output logic [FRAC_W-1:0]  cross_fraction
);

	localparam int NAW = $clog2(MAX_NODES);
	localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

	// control
	state_t            state_q, state_d;
	logic              out_valid_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_lim;
	logic              out_free;
	mac_ctl_t          mac_ctl;

	// query operands
	logic signed [31:0] px_q, py_q, dx_q, dy_q;
	logic               is_loc_q;
	logic [TAW-1:0]     idx_q;
	logic [CNT_W-1:0]   n_q;
	logic [1:0]         edge_q, pair_q, ph_q, vk_q;
	logic               oob_q;
	logic               res_hit_q;
	logic signed [31:0] vx_q [3];
	logic signed [31:0] vy_q [3];

	// edge-crossing terms and divider
	logic signed [ACC_W-1:0] det_q, sn_q, tn_q;
	logic [ACC_W-1:0]        rem_q, den_q, rem2;
	logic [FRAC_W-1:0]       quo_q;
	logic [3:0]              dcnt_q;
	logic                    rem_ge;

	// output register
	logic               hit_q;
	logic [10:0]        tri_out_q;
	logic [1:0]         edge_out_q;
	logic [FRAC_W-1:0]  frac_q;

	// store ports
	logic              node_we, tri_we;
	logic [NAW-1:0]    node_raddr;
	logic [TAW-1:0]    tri_raddr;
	logic [31:0]       nx_rdata, ny_rdata;
	logic [TRI_W-1:0]  tri_rdata;
	logic [VERT_W-1:0] vsel;
	logic              oob_cur;

	// shared multiplier operands
	logic [1:0]              ia, ib;
	logic signed [OP_W-1:0]  op_a, op_b;
	logic signed [OP_W-1:0]  dvx, dvy, ex, ey, wlx, wly, dx33, dy33;
	logic signed [ACC_W-1:0] diff;
	logic                    last_tri, s_ok, t_ok;

	function automatic logic signed [OP_W-1:0] sx(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
	endfunction

	// strictly between 0 and 1 as a fraction num/den
	function automatic logic in_unit(input logic signed [ACC_W-1:0] num,
			input logic signed [ACC_W-1:0] den);
		return (num != '0) && (num[ACC_W-1] == den[ACC_W-1]) && (mag(num) < mag(den));
	endfunction

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_lim   = (32'(count_q) < MAX_TRIANGLES) ? count_q : CNT_W'(MAX_TRIANGLES);
	assign last_tri  = (n_q + CNT_W'(1)) >= cnt_lim;

	// stores: writes are taken straight from the input transfer
	assign node_we   = in_valid && in_ready && (req_t'(req_type) == REQ_NODE)
			&& (32'(item_index) < MAX_NODES);
	assign tri_we    = in_valid && in_ready && (req_t'(req_type) == REQ_TRI)
			&& (32'(item_index) < MAX_TRIANGLES);
	assign tri_raddr = is_loc_q ? TAW'(n_q) : idx_q;
	assign vsel      = tri_rdata[vk_q * VERT_W +: VERT_W];
	assign node_raddr = NAW'(vsel);
	assign oob_cur   = 32'(vsel) >= MAX_NODES;

	tmpl_ram #(.W(32), .D(MAX_NODES)) u_node_x (
		.clk(clk), .we(node_we), .waddr(NAW'(item_index)), .wdata(coord_x),
		.raddr(node_raddr), .rdata(nx_rdata)
	);

	tmpl_ram #(.W(32), .D(MAX_NODES)) u_node_y (
		.clk(clk), .we(node_we), .waddr(NAW'(item_index)), .wdata(coord_y),
		.raddr(node_raddr), .rdata(ny_rdata)
	);

	tmpl_ram #(.W(TRI_W), .D(MAX_TRIANGLES)) u_tri (
		.clk(clk), .we(tri_we), .waddr(TAW'(item_index)),
		.wdata({vert_c, vert_b, vert_a}), .raddr(tri_raddr), .rdata(tri_rdata)
	);

	// operand selection: locate tests edge (e, e+1), edge query uses (i+1, i+2)
	always_comb begin
		ia   = next3(edge_q);
		ib   = is_loc_q ? edge_q : prev3(edge_q);
		dvx  = sx(vx_q[ia]) - sx(vx_q[ib]);
		dvy  = sx(vy_q[ia]) - sx(vy_q[ib]);
		ex   = sx(vx_q[ia]) - sx(px_q);
		ey   = sx(vy_q[ia]) - sx(py_q);
		wlx  = sx(px_q) - sx(vx_q[ib]);
		wly  = sx(py_q) - sx(vy_q[ib]);
		dx33 = sx(dx_q);
		dy33 = sx(dy_q);
		if (is_loc_q) begin
			op_a = (ph_q == 2'd0) ? dvx : dvy;
			op_b = (ph_q == 2'd0) ? wly : wlx;
		end else begin
			case (pair_q)
				2'd0: begin
					op_a = (ph_q == 2'd0) ? dx33 : dvx;
					op_b = (ph_q == 2'd0) ? dvy : dy33;
				end
				2'd1: begin
					op_a = (ph_q == 2'd0) ? dvy : dvx;
					op_b = (ph_q == 2'd0) ? ex : ey;
				end
				default: begin
					op_a = (ph_q == 2'd0) ? dx33 : dy33;
					op_b = (ph_q == 2'd0) ? ey : ex;
				end
			endcase
		end
	end

	tmpl_mac u_mac (
		.clk(clk), .ctl(mac_ctl), .op_a(op_a), .op_b(op_b), .diff(diff)
	);

	assign s_ok   = in_unit(sn_q, det_q);
	assign t_ok   = in_unit(tn_q, det_q);
	assign rem2   = {rem_q[ACC_W-2:0], 1'b0};
	assign rem_ge = rem2 >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sequencer: next state and unit control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mac_ctl  = '{mul_en: 1'b0, acc_ld: 1'b0};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (req_t'(req_type))
						REQ_LOCATE: state_d = (cnt_lim == '0) ? ST_DONE : ST_TRI_RD;
						REQ_EDGE: state_d = (32'(item_index) < MAX_TRIANGLES) ? ST_TRI_RD
								: ST_DONE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_TRI_RD: state_d = ST_NODE_RD;
			ST_NODE_RD: begin
				if (vk_q == 2'd2) begin
					state_d = ST_NODE_CAP;
				end
			end
			ST_NODE_CAP: state_d = ST_CALC;
			ST_CALC: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_ld = (ph_q == 2'd1);
				if (ph_q == 2'd2) begin
					if (is_loc_q) begin
						if (diff[ACC_W-1]) begin
							state_d = last_tri ? ST_DONE : ST_TRI_RD;
						end else if (edge_q == 2'd2) begin
							state_d = ST_DONE;
						end
					end else if (pair_q == 2'd0) begin
						if (diff == '0 && edge_q == 2'd2) begin
							state_d = ST_DONE;
						end
					end else if (pair_q == 2'd2) begin
						state_d = ST_CHECK_S;
					end
				end
			end
			ST_CHECK_S: begin
				if (s_ok) begin
					state_d = ST_CHECK_T;
				end else begin
					state_d = (edge_q == 2'd2) ? ST_DONE : ST_CALC;
				end
			end
			ST_CHECK_T: begin
				if (t_ok) begin
					state_d = ST_DIV;
				end else begin
					state_d = (edge_q == 2'd2) ? ST_DONE : ST_CALC;
				end
			end
			ST_DIV: begin
				if (dcnt_q == 4'd15) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					px_q      <= coord_x;
					py_q      <= coord_y;
					dx_q      <= disp_x;
					dy_q      <= disp_y;
					is_loc_q  <= (req_t'(req_type) == REQ_LOCATE);
					idx_q     <= TAW'(item_index);
					n_q       <= '0;
					edge_q    <= '0;
					pair_q    <= '0;
					ph_q      <= '0;
					res_hit_q <= 1'b0;
				end
			end
			ST_TRI_RD: vk_q <= '0;
			ST_NODE_RD: begin
				// hold the out-of-range flag for the word arriving next cycle
				vk_q  <= vk_q + 2'd1;
				oob_q <= oob_cur;
				if (vk_q != 2'd0) begin
					vx_q[vk_q - 2'd1] <= oob_q ? '0 : nx_rdata;
					vy_q[vk_q - 2'd1] <= oob_q ? '0 : ny_rdata;
				end
			end
			ST_NODE_CAP: begin
				vx_q[2] <= oob_q ? '0 : nx_rdata;
				vy_q[2] <= oob_q ? '0 : ny_rdata;
				edge_q  <= '0;
				pair_q  <= '0;
				ph_q    <= '0;
			end
			ST_CALC: begin
				if (ph_q != 2'd2) begin
					ph_q <= ph_q + 2'd1;
				end else if (is_loc_q) begin
					if (diff[ACC_W-1]) begin
						n_q <= n_q + CNT_W'(1);
					end else if (edge_q == 2'd2) begin
						res_hit_q <= 1'b1;
					end else begin
						edge_q <= edge_q + 2'd1;
						ph_q   <= '0;
					end
				end else begin
					ph_q <= '0;
					case (pair_q)
						2'd0: begin
							det_q <= diff;
							if (diff == '0) begin
								// parallel: skip this edge
								edge_q <= edge_q + 2'd1;
							end else begin
								pair_q <= 2'd1;
							end
						end
						2'd1: begin
							sn_q   <= diff;
							pair_q <= 2'd2;
						end
						default: tn_q <= diff;
					endcase
				end
			end
			ST_CHECK_S: begin
				rem_q  <= mag(sn_q);
				den_q  <= mag(det_q);
				quo_q  <= '0;
				dcnt_q <= '0;
				if (!s_ok) begin
					edge_q <= edge_q + 2'd1;
					pair_q <= '0;
				end
			end
			ST_CHECK_T: begin
				if (!t_ok) begin
					edge_q <= edge_q + 2'd1;
					pair_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? rem2 - den_q : rem2;
				quo_q  <= {quo_q[FRAC_W-2:0], rem_ge};
				dcnt_q <= dcnt_q + 4'd1;
				if (dcnt_q == 4'd15) begin
					res_hit_q <= 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					hit_q      <= res_hit_q;
					tri_out_q  <= (res_hit_q && is_loc_q) ? 11'(n_q) : '0;
					edge_out_q <= (res_hit_q && !is_loc_q) ? edge_q : '0;
					frac_q     <= (res_hit_q && !is_loc_q) ? quo_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign found_triangle = tri_out_q;
	assign crossed_edge   = edge_out_q;
	assign cross_fraction = frac_q;

`ifndef SYNTH
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (req_type == REQ_LOCATE || req_type == REQ_EDGE))
		|=> !in_ready)
		else $error("query transfer did not start the sequencer");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (found_triangle == '0 && crossed_edge == '0
		&& cross_fraction == '0))
		else $error("miss result carries non-zero fields");

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (crossed_edge != 2'd3))
		else $error("crossed edge out of range");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the triangle mesh point locator.
// Load a small mesh, walk a table of directed requests, load a few more triangles,
// scan with counts at and above the store size, then run random phases under different
// triangle counts. Every locate and edge answer is checked field by field, against a typed
// row answer or an in-bench predictor that redoes the geometry exactly with wide integers.
module tb_top;
	import tmpl_pkg::*;

	localparam int NODE_DEPTH = 1024;
	localparam int TRI_DEPTH  = 2048;
	localparam int ONE        = 1 << 16;      // 1.0 in Q16.16
	localparam int CYCLE_CAP  = 4_000_000;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		req_t               kind;
		logic [10:0]        idx;
		logic signed [31:0] x, y;
		logic [9:0]         va, vb, vc;
		logic signed [31:0] dx, dy;
	} mesh_req_t;

	typedef struct {
		logic        hit;
		logic [10:0] tri_idx;
		logic [1:0]  edg;
		logic [15:0] frac;
	} answer_t;

	typedef enum int {ROW_REQ, ROW_COUNT} row_kind_t;

	typedef struct {
		row_kind_t kind;
		mesh_req_t req;
		int        count;
		bit        typed;    // expected answer given in the row
		answer_t   ans;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         req_type;
	logic [10:0]        item_index;
	logic signed [31:0] coord_x, coord_y;
	logic [VERT_W-1:0]  vert_a, vert_b, vert_c;
	logic signed [31:0] disp_x, disp_y;
	logic               out_valid;
	logic               out_ready;
	logic               hit;
	logic [10:0]        found_triangle;
	logic [1:0]         crossed_edge;
	logic [FRAC_W-1:0]  cross_fraction;

	// predictor copy of the mesh and the count register
	longint     mesh_x [NODE_DEPTH];
	longint     mesh_y [NODE_DEPTH];
	logic [9:0] mesh_tri [TRI_DEPTH][3];
	int         scan_count;
	int         node_pool[$];
	bit         node_known [NODE_DEPTH];
	int         tri_fill;       // triangles 0 .. tri_fill-1 are loaded

	answer_t    pending_answers[$];
	stim_row_t  directed_rows[$];

	int  fail_count;
	int  req_total;
	int  answer_total;
	int  hit_total;
	int  cycle_count;
	bit  steady_run;        // no idling on either side while set
	bit  hold_request;
	int  hold_left;
	int  stall_left;

	triangle_mesh_point_locator_core #(
		.MAX_NODES(NODE_DEPTH),
		.MAX_TRIANGLES(TRI_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.item_index(item_index),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.vert_a(vert_a),
		.vert_b(vert_b),
		.vert_c(vert_c),
		.disp_x(disp_x),
		.disp_y(disp_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.found_triangle(found_triangle),
		.crossed_edge(crossed_edge),
		.cross_fraction(cross_fraction)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none while a steady stretch runs.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_run || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// exact signed product, widened before multiplying
	function automatic logic signed [127:0] wmul(longint a, longint b);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	function automatic logic signed [127:0] wabs(logic signed [127:0] v);
		return (v < 0) ? -v : v;
	endfunction

	// strictly between zero and one
	function automatic bit strictly_inside(logic signed [127:0] num, logic signed [127:0] den);
		if (num == 0 || ((num < 0) != (den < 0)))
			return 1'b0;
		return wabs(num) < wabs(den);
	endfunction

	function automatic bit tri_covers(int t, longint px, longint py);
		longint x1, y1, x2, y2;
		logic signed [127:0] side;
		for (int i = 0; i < 3; i++) begin
			x1 = mesh_x[mesh_tri[t][i]];
			y1 = mesh_y[mesh_tri[t][i]];
			x2 = mesh_x[mesh_tri[t][(i + 1) % 3]];
			y2 = mesh_y[mesh_tri[t][(i + 1) % 3]];
			side = wmul(x2 - x1, py - y1) - wmul(y2 - y1, px - x1);
			if (side < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic answer_t locate_answer(longint px, longint py);
		answer_t a;
		int lim;
		a = '{default: '0};
		lim = (scan_count < TRI_DEPTH) ? scan_count : TRI_DEPTH;
		for (int t = 0; t < lim; t++) begin
			if (tri_covers(t, px, py)) begin
				a.hit = 1'b1;
				a.tri_idx = t[10:0];
				return a;
			end
		end
		return a;
	endfunction

	// First edge, opposite vertex i, that the segment W..W+D crosses strictly.
	function automatic answer_t crossing_answer(int t, longint wx, longint wy,
			longint dx, longint dy);
		answer_t a;
		longint x0, y0, x1, y1, b, d, ex, ey;
		logic signed [127:0] det, sn, tn;
		logic [127:0] quot;
		a = '{default: '0};
		for (int i = 0; i < 3; i++) begin
			x0 = mesh_x[mesh_tri[t][(i + 1) % 3]];
			y0 = mesh_y[mesh_tri[t][(i + 1) % 3]];
			x1 = mesh_x[mesh_tri[t][(i + 2) % 3]];
			y1 = mesh_y[mesh_tri[t][(i + 2) % 3]];
			b  = x0 - x1;
			d  = y0 - y1;
			ex = x0 - wx;
			ey = y0 - wy;
			det = wmul(dx, d) - wmul(b, dy);
			if (det == 0)
				continue;
			sn = wmul(d, ex) - wmul(b, ey);
			tn = wmul(dx, ey) - wmul(dy, ex);
			if (strictly_inside(sn, det) && strictly_inside(tn, det)) begin
				quot = (128'(wabs(sn)) << 16) / 128'(wabs(det));
				a.hit = 1'b1;
				a.edg = i[1:0];
				a.frac = quot[15:0];
				return a;
			end
		end
		return a;
	endfunction

	// Update the mesh copy for one accepted request and queue its answer, if any.
	task automatic apply_request(mesh_req_t r, bit typed, answer_t typed_ans);
		answer_t a;
		case (r.kind)
			REQ_NODE: begin
				if (r.idx < NODE_DEPTH) begin
					mesh_x[r.idx] = r.x;
					mesh_y[r.idx] = r.y;
					if (!node_known[r.idx]) begin
						node_known[r.idx] = 1'b1;
						node_pool.push_back(r.idx);
					end
				end
			end
			REQ_TRI: begin
				mesh_tri[r.idx][0] = r.va;
				mesh_tri[r.idx][1] = r.vb;
				mesh_tri[r.idx][2] = r.vc;
				if (r.idx == tri_fill)
					tri_fill++;
			end
			REQ_LOCATE: begin
				a = typed ? typed_ans : locate_answer(r.x, r.y);
				pending_answers.push_back(a);
			end
			default: begin
				a = typed ? typed_ans : crossing_answer(r.idx, r.x, r.y, r.dx, r.dy);
				pending_answers.push_back(a);
			end
		endcase
	endtask

	// Offer one request, hold it until the transfer, then maybe idle.
	task automatic send_request(mesh_req_t r, bit typed, answer_t typed_ans);
		int g;
		req_type   <= r.kind;
		item_index <= r.idx;
		coord_x    <= r.x;
		coord_y    <= r.y;
		vert_a     <= r.va;
		vert_b     <= r.vb;
		vert_c     <= r.vc;
		disp_x     <= r.dx;
		disp_y     <= r.dy;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
		req_total++;
		apply_request(r, typed, typed_ans);
		g = idle_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every answer is in, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(int value);
		drain();
		cfg_data  <= value[CNT_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		scan_count = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] near_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $signed(32'($urandom_range(0, 16 * ONE))) - 8 * ONE;
	endfunction

	function automatic logic [9:0] pool_node();
		return node_pool[$urandom_range(0, node_pool.size() - 1)];
	endfunction

	function automatic mesh_req_t make_req(req_t k, int idx, int x, int y,
			int va, int vb, int vc, int dx, int dy);
		mesh_req_t r;
		r.kind = k;
		r.idx = idx[10:0];
		r.x = x;
		r.y = y;
		r.va = va[9:0];
		r.vb = vb[9:0];
		r.vc = vc[9:0];
		r.dx = dx;
		r.dy = dy;
		return r;
	endfunction

	function automatic stim_row_t req_row(mesh_req_t r);
		stim_row_t s;
		s.kind = ROW_REQ;
		s.req = r;
		s.count = 0;
		s.typed = 1'b0;
		s.ans = '{default: '0};
		return s;
	endfunction

	// a row whose answer is a plain miss
	function automatic stim_row_t miss_row(mesh_req_t r);
		stim_row_t s;
		s = req_row(r);
		s.typed = 1'b1;
		return s;
	endfunction

	function automatic stim_row_t count_row(int value);
		stim_row_t s;
		s = req_row(make_req(REQ_NODE, 0, 0, 0, 0, 0, 0, 0, 0));
		s.kind = ROW_COUNT;
		s.count = value;
		return s;
	endfunction

	// Random request: mostly well-formed queries aimed at loaded triangles.
	function automatic mesh_req_t random_req();
		mesh_req_t r;
		int t, sel;
		longint cx, cy;
		r = make_req(REQ_NODE, 0, 0, 0, 0, 0, 0, 0, 0);
		sel = $urandom_range(0, 9);
		r.idx = $urandom_range(0, TRI_DEPTH - 1);
		r.x = near_coord();
		r.y = near_coord();
		r.dx = near_coord();
		r.dy = near_coord();
		if (sel < 2) begin
			r.kind = REQ_NODE;
		end else if (sel < 4) begin
			// rewrite a loaded triangle or extend the loaded range by one
			r.kind = REQ_TRI;
			r.idx = 11'($urandom_range(0, tri_fill));
			r.va = pool_node();
			r.vb = pool_node();
			r.vc = pool_node();
		end else begin
			r.kind = (sel < 7) ? REQ_LOCATE : REQ_EDGE;
			if (r.kind == REQ_LOCATE) begin
				t = $urandom_range(0, (scan_count > 1) ? scan_count - 1 : 0) % TRI_DEPTH;
			end else begin
				if ($urandom_range(0, 9) == 0)
					r.idx = 11'(TRI_DEPTH - 1);
				else
					r.idx = 11'($urandom_range(0, tri_fill - 1));
				t = r.idx;
			end
			// aim at the centroid most of the time
			if ($urandom_range(0, 9) < 7) begin
				cx = (mesh_x[mesh_tri[t][0]] + mesh_x[mesh_tri[t][1]]
					+ mesh_x[mesh_tri[t][2]]) / 3;
				cy = (mesh_y[mesh_tri[t][0]] + mesh_y[mesh_tri[t][1]]
					+ mesh_y[mesh_tri[t][2]]) / 3;
				r.x = cx[31:0];
				r.y = cy[31:0];
			end
		end
		return r;
	endfunction

	// Result side: check each transfer, stall at random, honour a requested long hold-off.
	always @(posedge clk) begin
		answer_t e;
		int g;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				answer_total++;
				if (pending_answers.size() == 0) begin
					$error("unexpected result: hit=%0d tri=%0d edge=%0d frac=%0d",
						hit, found_triangle, crossed_edge, cross_fraction);
					fail_count++;
				end else begin
					e = pending_answers.pop_front();
					if (e.hit)
						hit_total++;
					if (hit !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, hit);
						fail_count++;
					end
					if (found_triangle !== e.tri_idx) begin
						$error("found_triangle: expected %0d, got %0d", e.tri_idx,
							found_triangle);
						fail_count++;
					end
					if (crossed_edge !== e.edg) begin
						$error("crossed_edge: expected %0d, got %0d", e.edg, crossed_edge);
						fail_count++;
					end
					if (cross_fraction !== e.frac) begin
						$error("cross_fraction: expected %0d, got %0d", e.frac,
							cross_fraction);
						fail_count++;
					end
				end
			end
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			g = idle_gap();
			stall_left = (g > 0) ? g - 1 : 0;
			out_ready <= (g == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
				pending_answers.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		mesh_req_t r;
		stim_row_t row;
		int phase_counts[5];

		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		out_ready  = 1'b0;
		req_type   = REQ_NODE;
		item_index = '0;
		coord_x    = '0;
		coord_y    = '0;
		vert_a     = '0;
		vert_b     = '0;
		vert_c     = '0;
		disp_x     = '0;
		disp_y     = '0;
		fail_count = 0;
		req_total  = 0;
		answer_total = 0;
		hit_total  = 0;
		cycle_count = 0;
		steady_run = 1'b0;
		hold_request = 1'b0;
		hold_left  = 0;
		stall_left = 0;
		scan_count = 0;
		tri_fill   = 0;
		for (int i = 0; i < NODE_DEPTH; i++) begin
			mesh_x[i] = 0;
			mesh_y[i] = 0;
			node_known[i] = 1'b0;
		end
		for (int i = 0; i < TRI_DEPTH; i++)
			for (int j = 0; j < 3; j++)
				mesh_tri[i][j] = '0;

		// Directed table: a small mesh with a corner at the origin, the coordinate extremes,
		// an ignored node write above the store, a degenerate triangle, zero count,
		// a zero displacement and queries that cross edges.
		directed_rows.push_back(req_row(make_req(REQ_NODE, 0, 0, 0, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_NODE, 1, 4 * ONE, 0, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_NODE, 2, 0, 4 * ONE, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_NODE, 3, 32'h8000_0000, 32'h8000_0000,
			0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_NODE, 1023, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_NODE, 1500, 7, 7, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_TRI, 0, 0, 0, 0, 1, 2, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_TRI, 1, 0, 0, 3, 1023, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_TRI, 2047, 0, 0, 0, 0, 0, 0, 0)));
		directed_rows.push_back(miss_row(make_req(REQ_LOCATE, 0, ONE, ONE, 0, 0, 0, 0, 0)));
		directed_rows.push_back(count_row(1));
		directed_rows.push_back(req_row(make_req(REQ_LOCATE, 0, ONE, ONE, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_LOCATE, 0, -5 * ONE, -5 * ONE,
			0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_LOCATE, 0, 0, 0, 0, 0, 0, 0, 0)));
		directed_rows.push_back(count_row(2));
		directed_rows.push_back(req_row(make_req(REQ_LOCATE, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_EDGE, 0, ONE, ONE, 0, 0, 0,
			4 * ONE, 4 * ONE)));
		directed_rows.push_back(miss_row(make_req(REQ_EDGE, 2047, ONE, ONE, 0, 0, 0,
			4 * ONE, 4 * ONE)));
		directed_rows.push_back(miss_row(make_req(REQ_EDGE, 0, ONE, ONE, 0, 0, 0, 0, 0)));
		directed_rows.push_back(req_row(make_req(REQ_EDGE, 1, 32'h8000_0000, 32'h7FFF_FFFF,
			0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000)));
		directed_rows.push_back(req_row(make_req(REQ_EDGE, 0, -ONE, ONE, 0, 0, 0,
			2 * ONE, 0)));
		directed_rows.push_back(req_row(make_req(REQ_EDGE, 0, 3 * ONE, -ONE, 0, 0, 0,
			-2 * ONE, 3 * ONE)));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_COUNT)
				write_count(row.count);
			else
				send_request(row.req, row.typed, row.ans);
		end

		// Load a few more triangles after the directed ones.
		for (int t = 2; t < 16; t++) begin
			r = make_req(REQ_TRI, t, 0, 0, pool_node(), pool_node(), pool_node(), 0, 0);
			send_request(r, 1'b0, '{default: '0});
		end

		// Full-range counts: above the store size, then exactly the store size.
		// Every point lies in the first triangle, so the scan stops there.
		write_count((1 << CNT_W) - 1);
		r = make_req(REQ_LOCATE, 0, ONE, ONE, 0, 0, 0, 0, 0);
		send_request(r, 1'b0, '{default: '0});
		r = make_req(REQ_LOCATE, 0, ONE, 2 * ONE, 0, 0, 0, 0, 0);
		send_request(r, 1'b0, '{default: '0});
		write_count(TRI_DEPTH);
		r = make_req(REQ_LOCATE, 0, 0, 0, 0, 0, 0, 0, 0);
		send_request(r, 1'b0, '{default: '0});

		// scan counts stay within the loaded triangles
		phase_counts[0] = 1;
		phase_counts[1] = 0;
		phase_counts[2] = $urandom_range(2, tri_fill);
		phase_counts[3] = $urandom_range(2, tri_fill);
		phase_counts[4] = tri_fill;
		for (int p = 0; p < 5; p++) begin
			write_count(phase_counts[p]);
			steady_run = (p == 2);
			// first phase: hold the result side off so the block backs up its input
			if (p == 0)
				hold_request = 1'b1;
			for (int n = 0; n < 20; n++) begin
				if (p == 3 && n == 10) begin
					// sender pause until every answer has arrived
					in_valid <= 1'b0;
					while (pending_answers.size() != 0)
						@(posedge clk);
				end
				if (p == 0 && n < 10)
					r = make_req(REQ_LOCATE, 0, near_coord(), near_coord(), 0, 0, 0, 0, 0);
				else
					r = random_req();
				send_request(r, 1'b0, '{default: '0});
			end
			steady_run = 1'b0;
		end

		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d requests and %0d checked answers (%0d hits) over counts 0..4095",
			req_total, answer_total, hit_total);
		$display("with long result-side hold-off, sender pause and steady stretches");
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/tmpl_pkg.sv
hdl/tmpl_ram.sv
hdl/tmpl_mac.sv
hdl/triangle_mesh_point_locator_core.sv
tb/tb_top.sv
